### design/lrf_pkg.sv
package lrf_pkg;

    // Default largest rectangle side, in pixels
    localparam int MAX_SIDE_DEFAULT = 256;

    // Panel controller commands
    localparam logic [7:0] CMD_COLUMN_ADDR = 8'h2a;
    localparam logic [7:0] CMD_ROW_ADDR    = 8'h2b;
    localparam logic [7:0] CMD_MEM_WRITE   = 8'h2c;

    // Input operations
    localparam logic OP_START = 1'b0;
    localparam logic OP_SLOT  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET    = 1'd1;

    // Configuration reset values
    localparam logic [7:0] COLUMN_OFFSET_RESET = 8'd1;
    localparam logic [7:0] ROW_OFFSET_RESET    = 8'd2;

    // Header sequence steps; PIXEL_PHASE follows the last header byte
    localparam logic [3:0] STEP_COL_CMD     = 4'd0;
    localparam logic [3:0] STEP_COL_FIRST_H = 4'd1;
    localparam logic [3:0] STEP_COL_FIRST_L = 4'd2;
    localparam logic [3:0] STEP_COL_FINAL_H = 4'd3;
    localparam logic [3:0] STEP_COL_FINAL_L = 4'd4;
    localparam logic [3:0] STEP_ROW_CMD     = 4'd5;
    localparam logic [3:0] STEP_ROW_FIRST_H = 4'd6;
    localparam logic [3:0] STEP_ROW_FIRST_L = 4'd7;
    localparam logic [3:0] STEP_ROW_FINAL_H = 4'd8;
    localparam logic [3:0] STEP_ROW_FINAL_L = 4'd9;
    localparam logic [3:0] STEP_MEM_CMD     = 4'd10;
    localparam logic [3:0] PIXEL_PHASE      = 4'd11;

    typedef struct packed {
        logic        operation;
        logic [7:0]  left;
        logic [7:0]  top;
        logic [8:0]  span_x;
        logic [8:0]  span_y;
        logic [15:0] fill_value;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_command;
        logic       last;
    } out_word_t;

endpackage

### design/lcd_rect_fill_sequencer_top.sv
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid / in_ready  | in_word_t: operation, rectangle, colour
// out     | output    | out_valid / out_ready| out_word_t: byte, command flag, last
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data (offsets)
//
// One input word per clock while in_ready is high; a slot word's byte appears in the output
// register in the cycle after acceptance. The span product is formed by one small multiplier
// at start. in_ready is low only while a result waits and out_ready is low.
// cfg_ready is always high. Reset (rst_n low, async) returns to idle with
// offsets 1 and 2.
module lcd_rect_fill_sequencer_top
    import lrf_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_word_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_word_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    localparam int SPAN_W  = $clog2(MAX_SIDE + 1);
    localparam int PIX_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int BOUND_W = $clog2(2 * 255 + MAX_SIDE);

    logic [7:0]         column_offset_reg;
    logic [7:0]         row_offset_reg;
    logic               active_reg, active_next;
    logic [3:0]         step_reg, step_next;
    logic [PIX_W-1:0]   pixels_left_reg, pixels_left_next;
    logic               low_half_reg, low_half_next;
    logic [BOUND_W-1:0] col_first_reg, col_first_next;
    logic [BOUND_W-1:0] col_final_reg, col_final_next;
    logic [BOUND_W-1:0] row_first_reg, row_first_next;
    logic [BOUND_W-1:0] row_final_reg, row_final_next;
    logic [15:0]        colour_reg, colour_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_data_reg;

    logic               in_fire;
    logic               res_valid;
    out_word_t          res;
    logic [SPAN_W-1:0]  span_x_c, span_y_c;
    logic [2*SPAN_W-1:0] area;
    logic [15:0]        col_first_w, col_final_w, row_first_w, row_final_w;

    // Span of zero counts as one, oversize spans saturate
    function automatic logic [SPAN_W-1:0] span_clamp(input logic [8:0] s);
        logic [SPAN_W-1:0] r;
        if (s == 9'd0)
            r = SPAN_W'(1);
        else if (32'(s) > 32'(MAX_SIDE))
            r = SPAN_W'(MAX_SIDE);
        else
            r = SPAN_W'(s);
        return r;
    endfunction

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign span_x_c = span_clamp(in_data.span_x);
    assign span_y_c = span_clamp(in_data.span_y);
    assign area     = (2*SPAN_W)'(span_x_c) * (2*SPAN_W)'(span_y_c);

    assign col_first_w = 16'(col_first_reg);
    assign col_final_w = 16'(col_final_reg);
    assign row_first_w = 16'(row_first_reg);
    assign row_final_w = 16'(row_final_reg);

    // Sequencer next state and result byte
    always_comb
    begin
        active_next      = active_reg;
        step_next        = step_reg;
        pixels_left_next = pixels_left_reg;
        low_half_next    = low_half_reg;
        col_first_next   = col_first_reg;
        col_final_next   = col_final_reg;
        row_first_next   = row_first_reg;
        row_final_next   = row_final_reg;
        colour_next      = colour_reg;
        res_valid        = 1'b0;
        res              = '0;
        if (in_fire)
        begin
            if (in_data.operation == OP_START)
            begin
                if (!active_reg)
                begin
                    col_first_next   = BOUND_W'(column_offset_reg) + BOUND_W'(in_data.left);
                    col_final_next   = BOUND_W'(column_offset_reg) + BOUND_W'(in_data.left)
                                       + BOUND_W'(span_x_c) - BOUND_W'(1);
                    row_first_next   = BOUND_W'(row_offset_reg) + BOUND_W'(in_data.top);
                    row_final_next   = BOUND_W'(row_offset_reg) + BOUND_W'(in_data.top)
                                       + BOUND_W'(span_y_c) - BOUND_W'(1);
                    colour_next      = in_data.fill_value;
                    pixels_left_next = PIX_W'(area);
                    low_half_next    = 1'b0;
                    step_next        = STEP_COL_CMD;
                    active_next      = 1'b1;
                end
            end
            else if (active_reg)
            begin
                res_valid = 1'b1;
                if (step_reg != PIXEL_PHASE)
                begin
                    step_next = step_reg + 4'd1;
                    case (step_reg)
                        STEP_COL_CMD:     res = '{CMD_COLUMN_ADDR, 1'b1, 1'b0};
                        STEP_COL_FIRST_H: res = '{col_first_w[15:8], 1'b0, 1'b0};
                        STEP_COL_FIRST_L: res = '{col_first_w[7:0], 1'b0, 1'b0};
                        STEP_COL_FINAL_H: res = '{col_final_w[15:8], 1'b0, 1'b0};
                        STEP_COL_FINAL_L: res = '{col_final_w[7:0], 1'b0, 1'b0};
                        STEP_ROW_CMD:     res = '{CMD_ROW_ADDR, 1'b1, 1'b0};
                        STEP_ROW_FIRST_H: res = '{row_first_w[15:8], 1'b0, 1'b0};
                        STEP_ROW_FIRST_L: res = '{row_first_w[7:0], 1'b0, 1'b0};
                        STEP_ROW_FINAL_H: res = '{row_final_w[15:8], 1'b0, 1'b0};
                        STEP_ROW_FINAL_L: res = '{row_final_w[7:0], 1'b0, 1'b0};
                        default:          res = '{CMD_MEM_WRITE, 1'b1, 1'b0};
                    endcase
                end
                else if (!low_half_reg)
                begin
                    res           = '{colour_reg[15:8], 1'b0, 1'b0};
                    low_half_next = 1'b1;
                end
                else
                begin
                    res           = '{colour_reg[7:0], 1'b0, (pixels_left_reg <= PIX_W'(1))};
                    low_half_next = 1'b0;
                    if (pixels_left_reg != '0)
                        pixels_left_next = pixels_left_reg - PIX_W'(1);
                    if (pixels_left_reg <= PIX_W'(1))
                    begin
                        active_next      = 1'b0;
                        step_next        = STEP_COL_CMD;
                        pixels_left_next = '0;
                    end
                end
            end
        end
    end

    // Output register valid
    always_comb
    begin
        if (in_fire)
            out_valid_next = res_valid;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            step_reg        <= STEP_COL_CMD;
            pixels_left_reg <= '0;
            low_half_reg    <= 1'b0;
            col_first_reg   <= '0;
            col_final_reg   <= '0;
            row_first_reg   <= '0;
            row_final_reg   <= '0;
            colour_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            active_reg      <= active_next;
            step_reg        <= step_next;
            pixels_left_reg <= pixels_left_next;
            low_half_reg    <= low_half_next;
            col_first_reg   <= col_first_next;
            col_final_reg   <= col_final_next;
            row_first_reg   <= row_first_next;
            row_final_reg   <= row_final_next;
            colour_reg      <= colour_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
            out_data_reg <= res;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_offset_reg <= COLUMN_OFFSET_RESET;
            row_offset_reg    <= ROW_OFFSET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COLUMN_OFFSET: column_offset_reg <= cfg_data;
                CFG_ROW_OFFSET:    row_offset_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

endmodule

### design/lrf_checker.sv
module lrf_checker
    import lrf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input in_word_t             in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input out_word_t            out_data,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [7:0]           cfg_data
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // A start word never produces a byte
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.operation == OP_START) |=> !out_valid)
        else $error("start word produced a byte");

    // An empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Command bytes are only the three panel commands
    a_cmd_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_command |->
            (out_data.out_byte == CMD_COLUMN_ADDR) || (out_data.out_byte == CMD_ROW_ADDR)
            || (out_data.out_byte == CMD_MEM_WRITE))
        else $error("unknown command byte");

    // The final byte is colour data, never a command
    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> !out_data.is_command)
        else $error("last flag on a command byte");

endmodule

bind lcd_rect_fill_sequencer_top lrf_checker u_lrf_checker (.*);
